>>> design/pcx_pkg.sv
// Shared types, codes and constants for the PNG chunk stream parser.
package pcx_pkg;

    // Byte classification codes carried on the kind output.
    localparam logic [2:0] KIND_SIG    = 3'd0;
    localparam logic [2:0] KIND_LEN    = 3'd1;
    localparam logic [2:0] KIND_TYPE   = 3'd2;
    localparam logic [2:0] KIND_DATA   = 3'd3;
    localparam logic [2:0] KIND_CRC    = 3'd4;
    localparam logic [2:0] KIND_HIDDEN = 3'd5;
    localparam logic [2:0] KIND_TRAIL  = 3'd6;
    localparam logic [2:0] KIND_ERR    = 3'd7;

    // Chunk type of the end chunk, "IEND" in ASCII.
    localparam logic [31:0] IEND_WORD = 32'h49454E44;

    // Value of the key register after reset.
    localparam logic [7:0] KEY_RESET = 8'hAF;

    // One classified byte as it leaves the parser.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       field_end;
        logic       payload_last;
        logic       after_end;
    } t_result;

    // Expected byte of the 8-byte file signature at a given position.
    function automatic logic [7:0] sig_byte(input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = 8'd137;
            3'd1:    b = 8'd80;
            3'd2:    b = 8'd78;
            3'd3:    b = 8'd71;
            3'd4:    b = 8'd13;
            3'd5:    b = 8'd10;
            3'd6:    b = 8'd26;
            default: b = 8'd10;
        endcase
        return b;
    endfunction

endpackage

>>> design/pcx_parser.sv
// Chunk walker: parse state registers and the per-byte classification logic.
module pcx_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_key,
    output pcx_pkg::t_result  o_res
);
    import pcx_pkg::*;

    // Parse phase codes.
    localparam logic [2:0] PH_SIG   = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_TYPE  = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CRC   = 3'd4;
    localparam logic [2:0] PH_TRAIL = 3'd5;
    localparam logic [2:0] PH_ERR   = 3'd6;

    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_len, n_len;
    logic [31:0] r_type, n_type;
    logic        r_end_seen, n_end_seen;
    logic [31:0] pos_inc;
    t_result     res;

    assign pos_inc = r_pos + 32'd1;

    // Classify the current word and work out the next parse state.
    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_len      = r_len;
        n_type     = r_type;
        n_end_seen = r_end_seen;
        res.kind         = KIND_ERR;
        res.value        = i_byte;
        res.field_end    = 1'b0;
        res.payload_last = 1'b0;
        res.after_end    = r_end_seen;
        unique case (r_phase)
            PH_SIG: begin
                if (i_byte != sig_byte(r_pos[2:0])) begin
                    n_phase = PH_ERR;
                end else begin
                    res.kind = KIND_SIG;
                    n_pos    = pos_inc;
                    if (r_pos[2:0] == 3'd7) begin
                        res.field_end = 1'b1;
                        n_pos         = '0;
                        n_phase       = PH_LEN;
                    end
                end
            end
            PH_LEN: begin
                res.kind = KIND_LEN;
                n_len    = (r_pos == '0) ? {24'd0, i_byte} : {r_len[23:0], i_byte};
                n_pos    = pos_inc;
                if (r_pos[1:0] == 2'd3) begin
                    res.field_end = 1'b1;
                    n_pos         = '0;
                    n_phase       = PH_TYPE;
                end
            end
            PH_TYPE: begin
                res.kind = KIND_TYPE;
                n_type   = (r_pos == '0) ? {24'd0, i_byte} : {r_type[23:0], i_byte};
                n_pos    = pos_inc;
                if (r_pos[1:0] == 2'd3) begin
                    res.field_end = 1'b1;
                    n_pos         = '0;
                    n_phase       = (r_len != '0) ? PH_DATA : PH_CRC;
                end
            end
            PH_DATA: begin
                // Data of the chunk after the end chunk is decoded with the key.
                if (r_end_seen) begin
                    res.kind  = KIND_HIDDEN;
                    res.value = i_byte ^ i_key;
                end else begin
                    res.kind = KIND_DATA;
                end
                n_pos = pos_inc;
                if (pos_inc >= r_len) begin
                    res.field_end    = 1'b1;
                    res.payload_last = r_end_seen;
                    n_pos            = '0;
                    n_phase          = PH_CRC;
                end
            end
            PH_CRC: begin
                res.kind = KIND_CRC;
                n_pos    = pos_inc;
                if (r_pos[1:0] == 2'd3) begin
                    res.field_end = 1'b1;
                    n_pos         = '0;
                    if (r_end_seen) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        if (r_type == IEND_WORD) begin
                            n_end_seen = 1'b1;
                        end
                        n_phase = PH_LEN;
                    end
                end
            end
            PH_TRAIL: begin
                res.kind = KIND_TRAIL;
            end
            default: begin
                n_phase = PH_ERR;
            end
        endcase
    end

    assign o_res = res;

    // Parse state advances once per word handed to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SIG;
            r_pos      <= '0;
            r_len      <= '0;
            r_type     <= '0;
            r_end_seen <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_type     <= n_type;
            r_end_seen <= n_end_seen;
        end
    end

endmodule

>>> design/png_chunk_hidden_payload_extractor.sv
// Top level: input register, chunk parser, result register and key register.
// Words pass from the input register through the parser into the result register.
// Throughput: one byte per cycle; the input register takes a new word each cycle
// while the result register is empty or being taken, and holds one while it waits.
// Reset (synchronous, active low) empties both registers, returns the parser to
// the signature phase and loads the key with 0xAF.
module png_chunk_hidden_payload_extractor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_file_byte,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_byte_kind,
    output logic [7:0] o_byte_value,
    output logic       o_field_end,
    output logic       o_payload_last,
    output logic       o_after_end_chunk
);
    import pcx_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic [7:0] r_key;
    logic       out_free;
    logic       step;
    logic       in_take;
    t_result    res;

    // Result register can take a word when empty or being drained.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Key register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= KEY_RESET;
        end else if (i_cfg_we) begin
            r_key <= i_cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_file_byte;
        end
    end

    pcx_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_key   (r_key),
        .o_res   (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_byte_kind       = r_out.kind;
    assign o_byte_value      = r_out.value;
    assign o_field_end       = r_out.field_end;
    assign o_payload_last    = r_out.payload_last;
    assign o_after_end_chunk = r_out.after_end;

    // The last payload byte is always a hidden data byte that closes its field.
    a_last_is_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.payload_last) |->
            (r_out.kind == KIND_HIDDEN && r_out.field_end))
        else $error("payload_last on a byte that is not a closing hidden byte");

    // Hidden bytes only come after the end chunk.
    a_hidden_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_HIDDEN) |-> r_out.after_end)
        else $error("hidden byte before the end chunk passed");

    // Error and trailing bytes never close a field.
    a_no_end_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == KIND_ERR || r_out.kind == KIND_TRAIL)) |->
            (!r_out.field_end && !r_out.payload_last))
        else $error("field end flagged on an error or trailing byte");

    // A word held in the input register is not lost while the output waits.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input register changed while stalled");

endmodule

>>> dv/png_chunk_hidden_payload_extractor_tb.sv
// Self-checking testbench for the PNG chunk parser with hidden payload extraction.
`timescale 1ns / 1ps

module png_chunk_hidden_payload_extractor_tb;
    import pcx_pkg::*;

    // Parser phases of the scoreboard's own copy of the block.
    typedef enum logic [2:0] {
        ST_SIG,
        ST_LEN,
        ST_TYPE,
        ST_DATA,
        ST_CRC,
        ST_TRAIL,
        ST_ERR
    } t_parse_state;

    // One row of the directed stimulus: the byte and the result it must give.
    typedef struct {
        logic [7:0] file_byte;
        t_result    res;
    } t_dir_row;

    // The eight signature bytes, first byte in the top bits.
    localparam logic [63:0] PNG_SIG = 64'h89504E470D0A1A0A;
    localparam int HIDDEN_SLICE = 24;
    localparam int HIDDEN_SLICES = 4;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       o_in_stall;
    logic [7:0] file_byte;
    logic       cfg_we;
    logic [7:0] cfg_data;
    logic       o_out_valid;
    logic       out_stall;
    logic [2:0] o_byte_kind;
    logic [7:0] o_byte_value;
    logic       o_field_end;
    logic       o_payload_last;
    logic       o_after_end_chunk;

    png_chunk_hidden_payload_extractor i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_file_byte      (file_byte),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_byte_kind      (o_byte_kind),
        .o_byte_value     (o_byte_value),
        .o_field_end      (o_field_end),
        .o_payload_last   (o_payload_last),
        .o_after_end_chunk(o_after_end_chunk)
    );

    // Scoreboard copy of the parser state and the key register.
    t_parse_state pst;
    logic [31:0]  fpos;
    logic [31:0]  clen;
    logic [31:0]  ctype;
    logic         iend_passed;
    logic [7:0]   key_model;

    t_result  bytes_due[$];
    t_dir_row dir_table[$];
    int       n_sent;
    int       n_checked;
    int       n_mismatch;
    int       send_calm;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("png_chunk_hidden_payload_extractor regression: fail");
        $finish;
    end

    // Classify one file byte and advance the scoreboard's parser state.
    function automatic t_result parse_byte(input logic [7:0] b);
        t_result r;
        r = '{kind: KIND_ERR, value: b, field_end: 1'b0, payload_last: 1'b0,
              after_end: iend_passed};
        case (pst)
            ST_SIG: begin
                if (b != PNG_SIG[63 - 8 * fpos[2:0] -: 8]) begin
                    pst = ST_ERR;
                end else begin
                    r.kind = KIND_SIG;
                    fpos = fpos + 1;
                    if (fpos >= 8) begin
                        r.field_end = 1'b1;
                        fpos = '0;
                        pst = ST_LEN;
                    end
                end
            end
            ST_LEN: begin
                r.kind = KIND_LEN;
                clen = (fpos == 0) ? {24'd0, b} : {clen[23:0], b};
                fpos = fpos + 1;
                if (fpos >= 4) begin
                    r.field_end = 1'b1;
                    fpos = '0;
                    pst = ST_TYPE;
                end
            end
            ST_TYPE: begin
                r.kind = KIND_TYPE;
                ctype = (fpos == 0) ? {24'd0, b} : {ctype[23:0], b};
                fpos = fpos + 1;
                if (fpos >= 4) begin
                    r.field_end = 1'b1;
                    fpos = '0;
                    pst = (clen != 0) ? ST_DATA : ST_CRC;
                end
            end
            ST_DATA: begin
                if (iend_passed) begin
                    r.kind = KIND_HIDDEN;
                    r.value = b ^ key_model;
                end else begin
                    r.kind = KIND_DATA;
                end
                fpos = fpos + 1;
                if (fpos >= clen) begin
                    r.field_end = 1'b1;
                    r.payload_last = iend_passed;
                    fpos = '0;
                    pst = ST_CRC;
                end
            end
            ST_CRC: begin
                r.kind = KIND_CRC;
                fpos = fpos + 1;
                if (fpos >= 4) begin
                    r.field_end = 1'b1;
                    fpos = '0;
                    if (iend_passed) begin
                        pst = ST_TRAIL;
                    end else begin
                        // Only a chunk ahead of the hidden one can be the end chunk.
                        if (ctype == IEND_WORD) iend_passed = 1'b1;
                        pst = ST_LEN;
                    end
                end
            end
            ST_TRAIL: begin
                r.kind = KIND_TRAIL;
            end
            default: begin
                pst = ST_ERR;
            end
        endcase
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Chunk data length: mostly short, some empty, a few of 200 to 300 bytes.
    function automatic logic [31:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 32'd0;
        if (r < 75) return $urandom_range(1, 8);
        if (r < 94) return $urandom_range(9, 40);
        return $urandom_range(200, 300);
    endfunction

    // Offer one word and wait until the block takes it; queue what it must give.
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_result typed_res);
        int      gap;
        t_result pred;
        if (send_calm > 0) begin
            gap = 0;
            send_calm--;
        end else if ($urandom_range(0, 99) < 4) begin
            gap = 0;
            send_calm = $urandom_range(20, 40);
        end else begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        file_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = parse_byte(b);
        bytes_due.push_back(typed ? typed_res : pred);
        n_sent++;
    endtask

    task automatic send_raw(input logic [7:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    // Length and type fields of one chunk.
    task automatic send_header(input logic [31:0] len, input logic [31:0] ctype_word);
        for (int i = 3; i >= 0; i--) send_raw(len[8 * i +: 8]);
        for (int i = 3; i >= 0; i--) send_raw(ctype_word[8 * i +: 8]);
    endtask

    task automatic send_crc();
        repeat (4) send_raw(8'($urandom_range(0, 255)));
    endtask

    // Stop offering and wait until every queued word has come out.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Key register write, only while the block is empty.
    task automatic write_key(input logic [7:0] k);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= k;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        key_model = k;
    endtask

    task automatic add_row(input logic [7:0] b, input logic [2:0] kind, input logic fend);
        t_dir_row row;
        row.file_byte = b;
        row.res = '{kind: kind, value: b, field_end: fend, payload_last: 1'b0,
                    after_end: 1'b0};
        dir_table.push_back(row);
    endtask

    // Stimulus: directed opening, random chunks, end chunk, hidden chunk, trailer.
    initial begin
        logic [31:0] len;
        logic [31:0] ctype_word;
        logic [7:0]  slice_key;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        file_byte = '0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        n_sent    = 0;
        send_calm = 0;
        pst         = ST_SIG;
        fpos        = '0;
        clen        = '0;
        ctype       = '0;
        iend_passed = 1'b0;
        key_model   = KEY_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Signature, then an empty chunk with all-ones type and mixed CRC bytes.
        for (int i = 0; i < 8; i++) add_row(PNG_SIG[63 - 8 * i -: 8], KIND_SIG, i == 7);
        for (int i = 0; i < 4; i++) add_row(8'h00, KIND_LEN, i == 3);
        for (int i = 0; i < 4; i++) add_row(8'hFF, KIND_TYPE, i == 3);
        for (int i = 0; i < 4; i++) add_row((i % 2) ? 8'hFF : 8'h00, KIND_CRC, i == 3);
        foreach (dir_table[i]) send_byte(dir_table[i].file_byte, 1'b1, dir_table[i].res);

        // Ordinary chunks with random sizes, types and contents.
        while (n_sent < 480) begin
            len = pick_len();
            ctype_word = $urandom;
            if (ctype_word == IEND_WORD) ctype_word[0] = ~ctype_word[0];
            send_header(len, ctype_word);
            for (int i = 0; i < len; i++) send_raw(8'($urandom_range(0, 255)));
            send_crc();
        end

        // End chunk, then the hidden chunk, itself named IEND.
        send_header(32'd0, IEND_WORD);
        send_crc();
        send_header(HIDDEN_SLICE * HIDDEN_SLICES, IEND_WORD);
        for (int s = 0; s < HIDDEN_SLICES; s++) begin
            // First slice decodes with the key left by reset.
            if (s > 0) begin
                slice_key = (s == 1) ? 8'h00 : (s == 2) ? 8'hFF : 8'($urandom_range(0, 255));
                write_key(slice_key);
            end
            repeat (HIDDEN_SLICE) send_raw(8'($urandom_range(0, 255)));
        end
        send_crc();
        repeat (30) send_raw(8'($urandom_range(0, 255)));

        // Drain and let any stray word show up before the verdict.
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (n_mismatch == 0 && bytes_due.size() == 0) begin
            $display("png_chunk_hidden_payload_extractor regression: pass");
        end else begin
            $display("png_chunk_hidden_payload_extractor regression: fail");
        end
        $finish;
    end

    // Receiver: random stalls, one long hold-off, and the result check.
    initial begin
        int      stall_left;
        bit      held_off;
        t_result exp_res;
        t_result act_res;
        stall_left = 0;
        held_off   = 1'b0;
        n_checked  = 0;
        n_mismatch = 0;
        out_stall  <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !out_stall) begin
                act_res = '{kind: o_byte_kind, value: o_byte_value, field_end: o_field_end,
                            payload_last: o_payload_last, after_end: o_after_end_chunk};
                if (bytes_due.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected word: kind %0d value %02h", act_res.kind,
                                 act_res.value);
                end else begin
                    exp_res = bytes_due.pop_front();
                    if (act_res !== exp_res) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display({"word %0d mismatch: exp kind %0d val %02h end %0b ",
                                      "last %0b after %0b, got kind %0d val %02h end %0b ",
                                      "last %0b after %0b"}, n_checked,
                                     exp_res.kind, exp_res.value, exp_res.field_end,
                                     exp_res.payload_last, exp_res.after_end,
                                     act_res.kind, act_res.value, act_res.field_end,
                                     act_res.payload_last, act_res.after_end);
                    end
                end
                n_checked++;
            end
            // Next stall decision; once, a long hold-off lets the block back up.
            if (!held_off && n_checked >= 200) begin
                held_off   = 1'b1;
                stall_left = 80;
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else if ($urandom_range(0, 99) < 25) begin
                out_stall  <= 1'b1;
                stall_left = pick_gap();
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

endmodule
